@@ hw/rtl/vpnt_pkg.sv @@
package vpnt_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned EntryW  = 16;
  localparam int unsigned ColW    = 64;
  localparam int unsigned ProdW   = CoordW + EntryW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned FracCut = 8;
  localparam int unsigned CfgIdxW = 4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODEL_COL0 = 4'd0,
    REG_MODEL_COL1 = 4'd1,
    REG_MODEL_COL2 = 4'd2,
    REG_MODEL_COL3 = 4'd3,
    REG_MVP_COL0   = 4'd4,
    REG_MVP_COL1   = 4'd5,
    REG_MVP_COL2   = 4'd6,
    REG_MVP_COL3   = 4'd7
  } cfg_reg_t;

  // Identity matrix columns.
  localparam logic [ColW-1:0] IdentCol0 = 64'h0000_0000_0000_0100;
  localparam logic [ColW-1:0] IdentCol1 = 64'h0000_0000_0100_0000;
  localparam logic [ColW-1:0] IdentCol2 = 64'h0000_0100_0000_0000;
  localparam logic [ColW-1:0] IdentCol3 = 64'h0100_0000_0000_0000;

  // A matrix as [column][row] of Q8.8 entries; row 0 sits in the low bits.
  typedef logic [3:0][3:0][EntryW-1:0] mat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] nrm_x;
    logic signed [CoordW-1:0] nrm_y;
    logic signed [CoordW-1:0] nrm_z;
  } vtx_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] world_x;
    logic signed [CoordW-1:0] world_y;
    logic signed [CoordW-1:0] world_z;
    logic signed [CoordW-1:0] wnrm_x;
    logic signed [CoordW-1:0] wnrm_y;
    logic signed [CoordW-1:0] wnrm_z;
    logic signed [CoordW-1:0] clip_x;
    logic signed [CoordW-1:0] clip_y;
    logic signed [CoordW-1:0] clip_z;
    logic signed [CoordW-1:0] clip_w;
  } vtx_out_t;

  // Per-stage load strobes from the pipeline control to the datapath.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctl_t;

endpackage

@@ hw/rtl/vpnt_cfg.sv @@
module vpnt_cfg
  import vpnt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ColW-1:0]    cfg_data,
  output mat_t               model_mat,
  output mat_t               mvp_mat
);

  mat_t model;
  mat_t mvp;

  always_ff @(posedge clk) begin
    if (rst) begin
      model <= {IdentCol3, IdentCol2, IdentCol1, IdentCol0};
      mvp   <= {IdentCol3, IdentCol2, IdentCol1, IdentCol0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODEL_COL0: model[0] <= cfg_data;
        REG_MODEL_COL1: model[1] <= cfg_data;
        REG_MODEL_COL2: model[2] <= cfg_data;
        REG_MODEL_COL3: model[3] <= cfg_data;
        REG_MVP_COL0:   mvp[0]   <= cfg_data;
        REG_MVP_COL1:   mvp[1]   <= cfg_data;
        REG_MVP_COL2:   mvp[2]   <= cfg_data;
        REG_MVP_COL3:   mvp[3]   <= cfg_data;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  assign model_mat = model;
  assign mvp_mat   = mvp;

endmodule

@@ hw/rtl/vpnt_row.sv @@
module vpnt_row
  import vpnt_pkg::*;
(
  input  logic                     clk,
  input  pipe_ctl_t                ctl,
  input  logic signed [EntryW-1:0] c0,
  input  logic signed [EntryW-1:0] c1,
  input  logic signed [EntryW-1:0] c2,
  input  logic signed [EntryW-1:0] c3,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  output logic signed [CoordW-1:0] res
);

  logic signed [ProdW-1:0]  p0;
  logic signed [ProdW-1:0]  p1;
  logic signed [ProdW-1:0]  p2;
  logic signed [CoordW-1:0] tw;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   rnd;
  logic [SumW-FracCut-1:0]  shr;
  logic [CoordW-1:0]        sat;

  // Stage 1: three products, translation aligned to Q24.24.
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      p0 <= ProdW'(c0 * x);
      p1 <= ProdW'(c1 * y);
      p2 <= ProdW'(c2 * z);
      tw <= {c3, 16'b0};
    end
  end

  // Stage 2: exact sum.
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      sum <= {{2{p0[ProdW-1]}}, p0} + {{2{p1[ProdW-1]}}, p1}
           + {{2{p2[ProdW-1]}}, p2} + {{(SumW-CoordW){tw[CoordW-1]}}, tw};
    end
  end

  // Stage 3: round half up, drop eight fraction bits, clamp to 32 bits.
  always_comb begin
    rnd = sum + SumW'(128);
    shr = rnd[SumW-1:FracCut];
    if (shr[SumW-FracCut-1:CoordW-1] == '0 || shr[SumW-FracCut-1:CoordW-1] == '1) begin
      sat = shr[CoordW-1:0];
    end else if (shr[SumW-FracCut-1]) begin
      sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      res <= sat;
    end
  end

endmodule

@@ hw/rtl/vpnt_ctrl.sv @@
module vpnt_ctrl
  import vpnt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pipe_ctl_t ctl
);

  logic v1;
  logic v2;
  logic v3;
  logic rdy1;
  logic rdy2;
  logic rdy3;

  // A stage may load when it is empty or when its content moves on.
  assign rdy3 = !v3 || !out_stall;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign ctl.ld1  = rdy1;
  assign ctl.ld2  = rdy2;
  assign ctl.ld3  = rdy3;
  assign in_stall = !rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3))
    else $error("input stalled with a free stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted item not held in stage 1");

  a_bubble_close: assert property (@(posedge clk) disable iff (rst)
    (v2 && !v3) |=> v3)
    else $error("item did not advance into an empty output stage");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && out_stall) |=> (v3 && (v2 || !$past(v2))))
    else $error("stalled pipeline lost an item");
`endif

endmodule

@@ hw/rtl/vertex_position_normal_transform.sv @@
// Channel  Valid      Stall      Payload    Notes
// input    in_valid   in_stall   in_data    one vertex (position and normal)
// output   out_valid  out_stall  out_data   world, normal and clip results
// config   cfg_we     -          cfg_data   cfg_index selects the column
//
// From acceptance to out_valid an item passes one stage of multipliers,
// one stage of four-input adds and one of rounding and clamping.
// One item is accepted every cycle while the output side keeps up.
// Reset (rst, synchronous) empties the pipeline and loads identity matrices.
// A stall on the output holds the last stage; earlier stages keep filling
// bubbles, and in_stall rises only when all three stages hold items.
module vertex_position_normal_transform
  import vpnt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vtx_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vtx_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ColW-1:0]    cfg_data
);

  mat_t      model_mat;
  mat_t      mvp_mat;
  pipe_ctl_t ctl;

  logic signed [CoordW-1:0] world [3];
  logic signed [CoordW-1:0] wnrm  [3];
  logic signed [CoordW-1:0] clip  [4];

  // Matrix columns; the user must change them only while the pipeline is empty, the block does not enforce it.
  vpnt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .model_mat (model_mat),
    .mvp_mat   (mvp_mat)
  );

  // Valid bits and per-stage load strobes shared by all row units.
  vpnt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Each result component is one matrix row dotted with the vertex. The
  // normal rows get a zero translation entry, so w is taken as zero.
  for (genvar r = 0; r < 3; r++) begin : g_model
    vpnt_row u_pos (
      .clk (clk),
      .ctl (ctl),
      .c0  (model_mat[0][r]),
      .c1  (model_mat[1][r]),
      .c2  (model_mat[2][r]),
      .c3  (model_mat[3][r]),
      .x   (in_data.pos_x),
      .y   (in_data.pos_y),
      .z   (in_data.pos_z),
      .res (world[r])
    );

    vpnt_row u_nrm (
      .clk (clk),
      .ctl (ctl),
      .c0  (model_mat[0][r]),
      .c1  (model_mat[1][r]),
      .c2  (model_mat[2][r]),
      .c3  ('0),
      .x   (in_data.nrm_x),
      .y   (in_data.nrm_y),
      .z   (in_data.nrm_z),
      .res (wnrm[r])
    );
  end

  for (genvar r = 0; r < 4; r++) begin : g_mvp
    vpnt_row u_clip (
      .clk (clk),
      .ctl (ctl),
      .c0  (mvp_mat[0][r]),
      .c1  (mvp_mat[1][r]),
      .c2  (mvp_mat[2][r]),
      .c3  (mvp_mat[3][r]),
      .x   (in_data.pos_x),
      .y   (in_data.pos_y),
      .z   (in_data.pos_z),
      .res (clip[r])
    );
  end

  always_comb begin
    out_data.world_x = world[0];
    out_data.world_y = world[1];
    out_data.world_z = world[2];
    out_data.wnrm_x  = wnrm[0];
    out_data.wnrm_y  = wnrm[1];
    out_data.wnrm_z  = wnrm[2];
    out_data.clip_x  = clip[0];
    out_data.clip_y  = clip[1];
    out_data.clip_z  = clip[2];
    out_data.clip_w  = clip[3];
  end

endmodule
